@@ design/multi_slot_repeat_timer_top_macros.svh @@
// assertion macros shared by the timer design
`ifndef MULTI_SLOT_REPEAT_TIMER_TOP_MACROS_SVH
`define MULTI_SLOT_REPEAT_TIMER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off while in reset
`define MSRT_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("msrt assertion failed");
// next-cycle implication, held off while in reset
`define MSRT_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("msrt assertion failed");
`else
`define MSRT_ASSERT_NOW(label, ck, rs, ante, cons)
`define MSRT_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

@@ design/msrt_pkg.sv @@
// ----------------------------------------------------------------------------
// msrt_pkg
// Types, codes and sizes shared by the repeating timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package msrt_pkg;

  localparam int SLOTS     = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int ID_W      = 4;
  // ids past 15 cannot be addressed, so the scan stops at the smaller bound
  localparam int SCAN_LAST = ((SLOTS < 16) ? SLOTS : 16) - 1;
  localparam int QDEPTH    = 4;
  localparam int QA_W      = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_STOP  = 2'd2,
    FN_AGAIN = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_REJ_ZERO,
    CLS_REJ_RANGE,
    CLS_START,
    CLS_STOP,
    CLS_AGAIN
  } cls_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ID_ZERO  = 2'd1,
    STAT_NO_TIMER = 2'd2
  } status_t;

  typedef enum logic {
    EV_STATUS = 1'b0,
    EV_EXPIRY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FLUSH
  } state_t;

  typedef struct packed {
    cls_t             cls;
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] slot;
    logic [31:0]      timeout_ms;
    logic [15:0]      repeat_count;
    logic [31:0]      interval_ms;
  } item_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] interval;
    logic [15:0] repeats;
  } entry_t;

endpackage

`default_nettype wire

@@ design/multi_slot_repeat_timer_top.sv @@
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer_top
// Timer table with repeat counts, driven by millisecond tick beats.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    func, timer_sel, timeout_ms, repeat_count,
//                                  interval_ms
//  out      out_valid / out_stall  event_kind, fired_id, status, repeats_left,
//                                  last
//
//  a command is handled in the idle state of the back end and gives one status beat
//  a tick is popped as the time counter steps; then slots 1..15 are walked
//  through the single-port slot memory: an idle slot is passed in the scan
//  state, an armed slot is read there and checked in eval, and flush ends it
//  the queue takes up to four beats while the back end is busy
//  reset (synchronous) clears the time counter, armed bits and queue
//  out_stall holds the output register and pauses the scan when a result waits
`default_nettype none

module multi_slot_repeat_timer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [3:0]  timer_sel,
  input  wire logic [31:0] timeout_ms,
  input  wire logic [15:0] repeat_count,
  input  wire logic [31:0] interval_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             event_kind,
  output logic [3:0]       fired_id,
  output logic [1:0]       status,
  output logic [15:0]      repeats_left,
  output logic             last
);

  logic            push;
  logic            full;
  logic            pop;
  logic            nonempty;
  msrt_pkg::item_t push_item;
  msrt_pkg::item_t head_item;

  msrt_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .timer_sel    (timer_sel),
    .timeout_ms   (timeout_ms),
    .repeat_count (repeat_count),
    .interval_ms  (interval_ms),
    .full         (full),
    .push         (push),
    .item         (push_item)
  );

  msrt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (push_item),
    .full     (full),
    .pop      (pop),
    .item_out (head_item),
    .nonempty (nonempty)
  );

  msrt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (nonempty),
    .q_item       (head_item),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .fired_id     (fired_id),
    .status       (status),
    .repeats_left (repeats_left),
    .last         (last)
  );

endmodule

`default_nettype wire

@@ design/msrt_front.sv @@
// ----------------------------------------------------------------------------
// msrt_front
// Takes input beats and sorts each into a tick or a checked command.
// ----------------------------------------------------------------------------
`default_nettype none

module msrt_front (
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 func,
  input  wire logic [3:0]                 timer_sel,
  input  wire logic [31:0]                timeout_ms,
  input  wire logic [15:0]                repeat_count,
  input  wire logic [31:0]                interval_ms,
  input  wire logic                       full,
  output logic                            push,
  output msrt_pkg::item_t                 item
);

  msrt_pkg::cls_t cmd_cls;

  always_comb begin
    case (msrt_pkg::func_t'(func))
      msrt_pkg::FN_START: cmd_cls = msrt_pkg::CLS_START;
      msrt_pkg::FN_STOP:  cmd_cls = msrt_pkg::CLS_STOP;
      msrt_pkg::FN_AGAIN: cmd_cls = msrt_pkg::CLS_AGAIN;
      default:            cmd_cls = msrt_pkg::CLS_TICK;
    endcase
  end

  always_comb begin
    item.id           = timer_sel;
    item.slot         = msrt_pkg::IDX_W'(timer_sel);
    item.timeout_ms   = timeout_ms;
    item.repeat_count = repeat_count;
    item.interval_ms  = interval_ms;
    if (cmd_cls == msrt_pkg::CLS_TICK) begin
      item.cls = msrt_pkg::CLS_TICK;
    end else if (timer_sel == '0) begin
      item.cls = msrt_pkg::CLS_REJ_ZERO;
    end else if (32'(timer_sel) >= 32'(msrt_pkg::SLOTS)) begin
      item.cls = msrt_pkg::CLS_REJ_RANGE;
    end else begin
      item.cls = cmd_cls;
    end
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

endmodule

`default_nettype wire

@@ design/msrt_fifo.sv @@
// ----------------------------------------------------------------------------
// msrt_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msrt_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire msrt_pkg::item_t  item_in,
  output logic                  full,
  input  wire logic             pop,
  output msrt_pkg::item_t       item_out,
  output logic                  nonempty
);

  msrt_pkg::item_t               slots_q [msrt_pkg::QDEPTH];
  logic [msrt_pkg::QA_W-1:0]     wr_ptr;
  logic [msrt_pkg::QA_W-1:0]     rd_ptr;
  logic [msrt_pkg::QA_W:0]       count;

  assign full     = (count == (msrt_pkg::QA_W + 1)'(msrt_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign item_out = slots_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/msrt_back.sv @@
// ----------------------------------------------------------------------------
// msrt_back
// Owns the time counter and slot table; runs commands and tick scans.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_slot_repeat_timer_top_macros.svh"

module msrt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire msrt_pkg::item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  event_kind,
  output logic [3:0]            fired_id,
  output logic [1:0]            status,
  output logic [15:0]           repeats_left,
  output logic                  last
);

  localparam logic [msrt_pkg::IDX_W-1:0] IDX_FIRST = msrt_pkg::IDX_W'(1);
  localparam logic [msrt_pkg::IDX_W-1:0] IDX_END   =
    msrt_pkg::IDX_W'(msrt_pkg::SCAN_LAST);

  msrt_pkg::state_t              state, state_next;
  logic [msrt_pkg::IDX_W-1:0]    idx, idx_next;
  logic [63:0]                   now, now_next;
  logic [msrt_pkg::SLOTS-1:0]    armed, armed_next;
  logic                          pend_valid, pend_valid_next;
  logic [3:0]                    pend_id, pend_id_next;
  logic [15:0]                   pend_left, pend_left_next;

  msrt_pkg::entry_t              mem [msrt_pkg::SLOTS];
  msrt_pkg::entry_t              rd_q;
  msrt_pkg::entry_t              wd;
  logic                          we, re;
  logic [msrt_pkg::IDX_W-1:0]    wa, ra;

  logic                          out_free;
  logic                          ld;
  msrt_pkg::kind_t               ld_kind;
  logic [3:0]                    ld_id;
  msrt_pkg::status_t             ld_status;
  logic [15:0]                   ld_reps;
  logic                          ld_last;

  logic                          fire;
  logic [15:0]                   left;
  logic                          scan_end;

  assign out_free = !out_valid || !out_stall;
  assign fire     = (rd_q.deadline <= now);
  assign left     = (rd_q.repeats != '0) ? (rd_q.repeats - 16'd1) : 16'd0;
  assign scan_end = (idx == IDX_END);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    now_next        = now;
    armed_next      = armed;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    pend_left_next  = pend_left;
    q_pop           = 1'b0;
    we              = 1'b0;
    wa              = idx;
    wd              = '0;
    re              = 1'b0;
    ra              = idx;
    ld              = 1'b0;
    ld_kind         = msrt_pkg::EV_STATUS;
    ld_id           = '0;
    ld_status       = msrt_pkg::STAT_OK;
    ld_reps         = '0;
    ld_last         = 1'b1;

    case (state)
      msrt_pkg::S_IDLE: begin
        if (q_valid && q_item.cls == msrt_pkg::CLS_TICK) begin
          now_next        = now + 64'd1;
          q_pop           = 1'b1;
          idx_next        = IDX_FIRST;
          pend_valid_next = 1'b0;
          state_next      = msrt_pkg::S_SCAN;
        end else if (q_valid && out_free) begin
          q_pop = 1'b1;
          ld    = 1'b1;
          ld_id = q_item.id;
          wa    = q_item.slot;
          wd    = '{deadline: now + 64'(q_item.timeout_ms),
                    interval: q_item.interval_ms,
                    repeats:  q_item.repeat_count};
          case (q_item.cls)
            msrt_pkg::CLS_REJ_ZERO:  ld_status = msrt_pkg::STAT_ID_ZERO;
            msrt_pkg::CLS_REJ_RANGE: ld_status = msrt_pkg::STAT_NO_TIMER;
            msrt_pkg::CLS_START: begin
              we                      = 1'b1;
              armed_next[q_item.slot] = 1'b1;
            end
            msrt_pkg::CLS_STOP: begin
              if (armed[q_item.slot]) begin
                armed_next[q_item.slot] = 1'b0;
              end else begin
                ld_status = msrt_pkg::STAT_NO_TIMER;
              end
            end
            msrt_pkg::CLS_AGAIN: begin
              if (armed[q_item.slot]) begin
                we = 1'b1;
              end else begin
                ld_status = msrt_pkg::STAT_NO_TIMER;
              end
            end
            default: ld_status = msrt_pkg::STAT_OK;
          endcase
        end
      end

      msrt_pkg::S_SCAN: begin
        if (armed[idx]) begin
          re         = 1'b1;
          ra         = idx;
          state_next = msrt_pkg::S_EVAL;
        end else if (scan_end) begin
          state_next = msrt_pkg::S_FLUSH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      msrt_pkg::S_EVAL: begin
        // a fired slot waits here until the held result can move out
        if (!fire || !pend_valid || out_free) begin
          if (fire) begin
            if (pend_valid) begin
              ld        = 1'b1;
              ld_kind   = msrt_pkg::EV_EXPIRY;
              ld_id     = pend_id;
              ld_reps   = pend_left;
              ld_last   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = 4'(idx);
            pend_left_next  = left;
            we              = 1'b1;
            wa              = idx;
            wd              = '{deadline: now + 64'(rd_q.interval),
                                interval: rd_q.interval,
                                repeats:  left};
            if (left == '0) begin
              armed_next[idx] = 1'b0;
            end
          end
          if (scan_end) begin
            state_next = msrt_pkg::S_FLUSH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = msrt_pkg::S_SCAN;
          end
        end
      end

      msrt_pkg::S_FLUSH: begin
        if (!pend_valid) begin
          state_next = msrt_pkg::S_IDLE;
        end else if (out_free) begin
          ld              = 1'b1;
          ld_kind         = msrt_pkg::EV_EXPIRY;
          ld_id           = pend_id;
          ld_reps         = pend_left;
          ld_last         = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = msrt_pkg::S_IDLE;
        end
      end

      default: state_next = msrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= msrt_pkg::S_IDLE;
      idx        <= '0;
      now        <= '0;
      armed      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      now        <= now_next;
      armed      <= armed_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_id   <= pend_id_next;
    pend_left <= pend_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      event_kind   <= ld_kind;
      fired_id     <= ld_id;
      status       <= ld_status;
      repeats_left <= ld_reps;
      last         <= ld_last;
    end
  end

  `MSRT_ASSERT_NOW(a_no_overwrite, clk, rst, out_valid && out_stall, !ld)
  `MSRT_ASSERT_NOW(a_pop_idle, clk, rst, state != msrt_pkg::S_IDLE, !q_pop)
  `MSRT_ASSERT_NOW(a_idle_empty, clk, rst, state == msrt_pkg::S_IDLE, !pend_valid)
  `MSRT_ASSERT_NEXT(a_flush_last, clk, rst,
    state == msrt_pkg::S_FLUSH && pend_valid && out_free, out_valid && last)

endmodule

`default_nettype wire
